FILE: rtl/tfc_pkg.sv
`default_nettype none
package tfc_pkg;

  localparam logic [15:0] KA = 16'd13900;
  localparam logic [15:0] KB = 16'd20854;
  localparam logic [15:0] KC = 16'd27800;
  localparam logic [15:0] KD = 16'd53622;

  localparam logic [7:0] FULL_HI = 8'd255;
  localparam logic [7:0] FULL_LO = 8'd240;

  localparam int unsigned PIPE_DEPTH = 9;

  typedef enum logic [1:0] {
    RM_ZERO,
    RM_FULL,
    RM_DIV
  } ramp_mode_t;

  typedef struct packed {
    logic signed [18:0] num;
    logic [15:0]        den;
    logic               full_lo;
  } ramp_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/thermal_false_color_map_top.sv
// Channel | Direction | tdata fields (low bit up)                         | tuser/tlast
// s_axis  | in        | temperature[15:0]                                  | none
// m_axis  | out       | pixel_rgb565[15:0] red[23:16] green[31:24] blue[39:32] | none
// cfg     | in        | cfg_we, cfg_index (0 min_temp, 1 max_temp), cfg_data | none
//
// One transaction is accepted per clock while the output is not stalled.
// The depth includes the one-bit-per-step restoring divider, two steps per stage.
// The synchronous reset clears the valid bits and sets min_temp 0, max_temp 2560.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none
module thermal_false_color_map_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // temperature[15:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // pixel_rgb565, red, green, blue levels
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic signed [15:0] min_temp;
  logic signed [15:0] max_temp;
  logic [tfc_pkg::PIPE_DEPTH-1:0] valid;
  logic en;

  logic signed [17:0] v, lo, hi, a, b, c, d;
  logic               nonempty;

  tfc_pkg::ramp_cmd_t red_cmd, green_cmd, blue_cmd;
  tfc_pkg::ramp_cmd_t red_next, green_next, blue_next;
  logic [7:0] red_level, green_level, blue_level;

  assign en            = !valid[tfc_pkg::PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = valid[tfc_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_temp <= 16'sd0;
      max_temp <= 16'sd2560;
    end else if (cfg_we) begin
      if (cfg_index) begin
        max_temp <= cfg_data;
      end else begin
        min_temp <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[tfc_pkg::PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  tfc_thresh u_thresh (
    .clk         (clk),
    .en          (en),
    .temperature (s_axis_tdata),
    .min_temp    (min_temp),
    .max_temp    (max_temp),
    .v           (v),
    .lo          (lo),
    .hi          (hi),
    .a           (a),
    .b           (b),
    .c           (c),
    .d           (d),
    .nonempty    (nonempty)
  );

  always_comb begin
    red_next   = '{num: 19'(v) - 19'(b), den: 16'(c - b), full_lo: 1'b0};
    green_next = '{num: 19'sd0, den: 16'd0, full_lo: 1'b0};
    blue_next  = '{num: 19'sd0, den: 16'd0, full_lo: 1'b0};
    if (v > lo && v < a) begin
      green_next = '{num: 19'(v) - 19'(lo), den: 16'(a - lo), full_lo: 1'b0};
    end else if (v >= a && v <= c) begin
      green_next = '{num: 19'sd1, den: 16'd0, full_lo: 1'b0};
    end else if (v > c) begin
      green_next = '{num: 19'(d) - 19'(v), den: 16'(d - c), full_lo: 1'b0};
    end
    if (v <= b) begin
      blue_next = '{num: 19'(b) - 19'(v), den: 16'(b - a), full_lo: 1'b0};
    end else if (v > d) begin
      blue_next = '{num: 19'(v) - 19'(d), den: 16'(hi - d), full_lo: 1'b1};
    end
    if (!nonempty) begin
      red_next.num   = 19'sd0;
      green_next.num = 19'sd0;
      blue_next.num  = 19'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_cmd   <= red_next;
      green_cmd <= green_next;
      blue_cmd  <= blue_next;
    end
  end

  tfc_ramp u_red (.clk(clk), .en(en), .cmd(red_cmd), .level(red_level));
  tfc_ramp u_green (.clk(clk), .en(en), .cmd(green_cmd), .level(green_level));
  tfc_ramp u_blue (.clk(clk), .en(en), .cmd(blue_cmd), .level(blue_level));

  assign m_axis_tdata = {blue_level, green_level, red_level,
                         blue_level[7:3], green_level[7:2], red_level[7:3]};

endmodule
`default_nettype wire

FILE: rtl/tfc_thresh.sv
`default_nettype none
module tfc_thresh (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] temperature,
  input  wire logic signed [15:0] min_temp,
  input  wire logic signed [15:0] max_temp,
  output logic signed [17:0]      v,
  output logic signed [17:0]      lo,
  output logic signed [17:0]      hi,
  output logic signed [17:0]      a,
  output logic signed [17:0]      b,
  output logic signed [17:0]      c,
  output logic signed [17:0]      d,
  output logic                    nonempty
);

  logic signed [16:0] span;
  logic signed [17:0] v1;
  logic signed [17:0] lo1;
  logic signed [17:0] hi1;
  logic               nz1;
  logic [31:0]        pa;
  logic [31:0]        pb;
  logic [31:0]        pc;
  logic [31:0]        pd;

  assign span = 17'(max_temp) - 17'(min_temp);

  always_ff @(posedge clk) begin
    if (en) begin
      v1  <= 18'(temperature);
      lo1 <= 18'(min_temp);
      hi1 <= 18'(max_temp);
      nz1 <= (span > 17'sd0);
      pa  <= span[15:0] * tfc_pkg::KA;
      pb  <= span[15:0] * tfc_pkg::KB;
      pc  <= span[15:0] * tfc_pkg::KC;
      pd  <= span[15:0] * tfc_pkg::KD;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v        <= v1;
      lo       <= lo1;
      hi       <= hi1;
      nonempty <= nz1;
      a        <= lo1 + $signed({2'b00, pa[31:16]});
      b        <= lo1 + $signed({2'b00, pb[31:16]});
      c        <= lo1 + $signed({2'b00, pc[31:16]});
      d        <= lo1 + $signed({2'b00, pd[31:16]});
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tfc_ramp.sv
`default_nettype none
module tfc_ramp (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire tfc_pkg::ramp_cmd_t cmd,
  output logic [7:0]             level
);

  tfc_pkg::ramp_mode_t mode1;
  logic [15:0]         num1;
  logic [15:0]         den1;
  logic                fl1;

  tfc_pkg::ramp_mode_t mode2;
  logic [23:0]         prod2;
  logic [15:0]         den2;
  logic                fl2;

  tfc_pkg::ramp_mode_t mode_d [4];
  logic [23:0]         rem_d  [4];
  logic [7:0]          q_d    [4];
  logic [15:0]         den_d  [4];
  logic                fl_d   [4];

  tfc_pkg::ramp_mode_t mode_sel;

  always_comb begin
    if (cmd.num <= 19'sd0) begin
      mode_sel = tfc_pkg::RM_ZERO;
    end else if (cmd.num[17:0] >= {2'b00, cmd.den}) begin
      mode_sel = tfc_pkg::RM_FULL;
    end else begin
      mode_sel = tfc_pkg::RM_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1 <= mode_sel;
      num1  <= cmd.num[15:0];
      den1  <= cmd.den;
      fl1   <= cmd.full_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode2 <= mode1;
      prod2 <= (fl1 ? tfc_pkg::FULL_LO : tfc_pkg::FULL_HI) * num1;
      den2  <= den1;
      fl2   <= fl1;
    end
  end

  for (genvar s = 0; s < 4; s++) begin : g_div
    logic [23:0]         rem_in;
    logic [7:0]          q_in;
    logic [15:0]         den_in;
    tfc_pkg::ramp_mode_t mode_in;
    logic                fl_in;
    logic [23:0]         rem_mid;
    logic [23:0]         rem_out;
    logic [7:0]          q_out;
    logic [24:0]         trial_hi;
    logic [24:0]         trial_lo;

    if (s == 0) begin : g_first
      assign rem_in  = prod2;
      assign q_in    = 8'd0;
      assign den_in  = den2;
      assign mode_in = mode2;
      assign fl_in   = fl2;
    end else begin : g_next
      assign rem_in  = rem_d[s-1];
      assign q_in    = q_d[s-1];
      assign den_in  = den_d[s-1];
      assign mode_in = mode_d[s-1];
      assign fl_in   = fl_d[s-1];
    end

    always_comb begin
      q_out    = q_in;
      trial_hi = {1'b0, rem_in} - ({9'd0, den_in} << (7 - 2 * s));
      if (!trial_hi[24]) begin
        rem_mid          = trial_hi[23:0];
        q_out[7 - 2 * s] = 1'b1;
      end else begin
        rem_mid = rem_in;
      end
      trial_lo = {1'b0, rem_mid} - ({9'd0, den_in} << (6 - 2 * s));
      if (!trial_lo[24]) begin
        rem_out          = trial_lo[23:0];
        q_out[6 - 2 * s] = 1'b1;
      end else begin
        rem_out = rem_mid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_d[s]  <= rem_out;
        q_d[s]    <= q_out;
        den_d[s]  <= den_in;
        mode_d[s] <= mode_in;
        fl_d[s]   <= fl_in;
      end
    end
  end

  always_comb begin
    unique case (mode_d[3])
      tfc_pkg::RM_FULL: level = fl_d[3] ? tfc_pkg::FULL_LO : tfc_pkg::FULL_HI;
      tfc_pkg::RM_DIV:  level = q_d[3];
      default:          level = 8'd0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/tfc_checker.sv
`default_nettype none
module tfc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Output valid after reset.");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("Input stalled with an empty output.");

  a_pack: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[4:0] == m_axis_tdata[23:19]) &&
                      (m_axis_tdata[10:5] == m_axis_tdata[31:26]) &&
                      (m_axis_tdata[15:11] == m_axis_tdata[39:35]))
    else $error("Packed pixel does not match the levels.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled output transaction changed.");

endmodule

bind thermal_false_color_map_top tfc_checker u_tfc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] rgb565;
  } pixel_t;

  localparam logic CFG_MIN = 1'b0;
  localparam logic CFG_MAX = 1'b1;
  localparam int LATENCY = 9;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  thermal_false_color_map_top DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic signed [15:0] cold_temp = 16'sd0;
  logic signed [15:0] hot_temp = 16'sd2560;
  logic [15:0] sample_queue[$];
  pixel_t pixel_queue[$];
  int mismatches = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_off = 0;
  bit pause_send = 1'b0;
  bit random_gaps = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] ramp_level(longint num, longint den, longint full);
    longint q;
    if (num <= 0) return 8'd0;
    q = (full * num) / den;
    if (q > full) q = full;
    return q[7:0];
  endfunction

  function automatic pixel_t palette_pixel(logic signed [15:0] temp);
    longint v, lo, hi, span, a, b, c, d;
    pixel_t p;
    v = temp;
    lo = cold_temp;
    hi = hot_temp;
    p = '0;
    if (hi > lo) begin
      span = hi - lo;
      a = lo + ((span * tfc_pkg::KA) >>> 16);
      b = lo + ((span * tfc_pkg::KB) >>> 16);
      c = lo + ((span * tfc_pkg::KC) >>> 16);
      d = lo + ((span * tfc_pkg::KD) >>> 16);
      if (c > b) p.red = ramp_level(v - b, c - b, 255);
      else p.red = (v > b) ? 8'd255 : 8'd0;
      if (v > lo && v < a) p.green = ramp_level(v - lo, a - lo, 255);
      else if (v >= a && v <= c) p.green = 8'd255;
      else if (v > c) p.green = (d > c) ? ramp_level(d - v, d - c, 255) : 8'd0;
      if (v <= b) begin
        if (b > a) p.blue = ramp_level(b - v, b - a, 255);
        else p.blue = (v < b) ? 8'd255 : 8'd0;
      end else if (v > d) begin
        p.blue = ramp_level(v - d, hi - d, 240);
      end
    end
    p.rgb565 = {p.blue[7:3], p.green[7:2], p.red[7:3]};
    return p;
  endfunction

  function automatic int pick_gap();
    if (!random_gaps) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pixel_queue.push_back(palette_pixel($signed(s_axis_tdata)));
      end
      if (s_axis_tvalid && !s_axis_tready) begin
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (sample_queue.size() > 0 && !pause_send) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sample_queue.pop_front();
        send_gap <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pixel_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pixel %h", got);
        end else begin
          want = pixel_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: expected %h actual %h", want, got);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  task automatic wait_drained();
    while (sample_queue.size() > 0 || s_axis_tvalid || pixel_queue.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic signed [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN) cold_temp = val;
    else hot_temp = val;
    @(posedge clk);
  endtask

  task automatic send_span(int count, logic signed [15:0] lo, logic signed [15:0] hi);
    int i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        sample_queue.push_back(16'($urandom_range(0, 65535)));
      else if ($urandom_range(0, 9) == 0)
        sample_queue.push_back(16'($signed(-2560) + int'($urandom_range(0, 21760))));
      else
        sample_queue.push_back(16'(int'(lo) - 20 + int'($urandom_range(0, int'(hi) - int'(lo) + 40))));
    end
  endtask

  initial begin
    logic signed [15:0] lo, hi;
    int phase;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sample_queue.push_back(16'h8000);
    sample_queue.push_back(16'h7FFF);
    sample_queue.push_back(16'hFFFF);
    sample_queue.push_back(16'h0000);
    sample_queue.push_back(16'hF600);
    sample_queue.push_back(16'h4B00);
    for (int t = 0; t <= 2560; t += 200) sample_queue.push_back(16'(t));
    sample_queue.push_back(16'd543);
    sample_queue.push_back(16'd814);
    sample_queue.push_back(16'd1086);
    sample_queue.push_back(16'd2094);
    sample_queue.push_back(16'd2559);
    wait_drained();
    write_reg(CFG_MIN, 16'sd100);
    write_reg(CFG_MAX, 16'sd103);
    for (int t = 95; t <= 108; t++) sample_queue.push_back(16'(t));
    wait_drained();
    write_reg(CFG_MAX, 16'sd100);
    sample_queue.push_back(16'd100);
    sample_queue.push_back(16'd50);
    wait_drained();
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin lo = -16'sd2560; hi = 16'sd19200; end
        1: begin lo = 16'sd19200; hi = -16'sd2560; end
        2: begin lo = 16'sd0; hi = 16'sd7; end
        default: begin
          lo = 16'($signed(-2560) + int'($urandom_range(0, 21760)));
          hi = 16'(int'(lo) + int'($urandom_range(1, 19200 - int'(lo))));
          if (hi > 16'sd19200) hi = 16'sd19200;
        end
      endcase
      write_reg(CFG_MIN, lo);
      write_reg(CFG_MAX, hi);
      random_gaps = (phase != 4);
      if (phase == 3) hold_off = 200;
      send_span(85, (lo < hi) ? lo : hi, (lo < hi) ? hi : lo);
      if (phase == 5) begin
        while (sample_queue.size() > 40) @(posedge clk);
        pause_send = 1'b1;
        while (s_axis_tvalid || pixel_queue.size() > 0) @(posedge clk);
        pause_send = 1'b0;
      end
      wait_drained();
    end
    if (mismatches == 0 && pixel_queue.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("testbench: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
